/* hdl/keyed_depth_arx_hash_mixer_core_assert.svh */
// assertion macros for the hash mixer core
`ifndef KEYED_DEPTH_ARX_HASH_MIXER_CORE_ASSERT_SVH
`define KEYED_DEPTH_ARX_HASH_MIXER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define KDAHM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define KDAHM_NEVER(lbl, expr, msg) `KDAHM_ASSERT(lbl, !(expr), msg)
`else
`define KDAHM_ASSERT(lbl, prop, msg)
`define KDAHM_NEVER(lbl, expr, msg)
`endif
`endif

/* hdl/kdahm_pkg.sv */
package kdahm_pkg;

	localparam int NUM_KEYS   = 4;
	localparam int IDX_W      = 3;
	localparam int NUM_ROUNDS = 7;
	localparam int SQ_STAGES  = 4;
	localparam int SQ_STEPS   = 4;
	localparam int LATENCY    = 12;

	localparam logic [63:0] GOLDEN_K = 64'h9E3779B97F4A7C15;
	localparam logic [31:0] DEPTH_K  = 32'hE7037ED1;

	typedef logic [63:0] word_t;
	typedef logic [5:0]  depth_t;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] r;
	} sq_t;

	typedef struct packed {
		logic [63:0] p0;
		logic [31:0] p1;
		logic [31:0] p2;
	} pp_t;

	function automatic logic [4:0] round_prime(input int i);
		case (i)
			0: return 5'd3;
			1: return 5'd5;
			2: return 5'd7;
			3: return 5'd11;
			4: return 5'd13;
			5: return 5'd17;
			default: return 5'd19;
		endcase
	endfunction

	function automatic word_t round_mul(input int i);
		word_t k;
		k = GOLDEN_K * {59'd0, round_prime(i)};
		return k;
	endfunction

	function automatic logic [5:0] round_rot(input int i);
		logic [7:0] t;
		t = 8'(13 + 7 * i);
		return t[5:0];
	endfunction

	function automatic word_t arx_mul(input logic [1:0] sel);
		word_t k;
		case (sel)
			2'd0: k = GOLDEN_K * 64'd19;
			2'd1: k = GOLDEN_K * 64'd29;
			default: k = GOLDEN_K * 64'd47;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] arx_rot(input logic [1:0] sel);
		case (sel)
			2'd0: return 6'd13;
			2'd1: return 6'd23;
			default: return 6'd43;
		endcase
	endfunction

	function automatic logic [1:0] mod3(input depth_t d);
		logic [3:0] t;
		t = {2'b0, d[1:0]} + {2'b0, d[3:2]} + {2'b0, d[5:4]};
		if (t >= 4'd6)
			t = t - 4'd6;
		if (t >= 4'd3)
			t = t - 4'd3;
		return t[1:0];
	endfunction

	function automatic word_t rotl(input word_t v, input logic [5:0] r);
		return (r == 6'd0) ? v : ((v << r) | (v >> (7'd64 - {1'b0, r})));
	endfunction

	function automatic depth_t word_depth(input word_t v);
		logic [6:0] bl;
		logic [6:0] pc;
		word_t      mid;
		logic [7:0] t;
		bl = '0;
		pc = '0;
		for (int i = 0; i < 64; i++) begin
			if (v[i])
				bl = 7'(i + 1);
			pc = pc + {6'd0, v[i]};
		end
		mid = v >> bl[6:1];
		t = {1'b0, bl} ^ {pc, 1'b0} ^ mid[7:0];
		return t[5:0];
	endfunction

	function automatic sq_t sq_step(input sq_t q, input logic [31:0] b);
		sq_t o;
		if (q.s >= q.r + b) begin
			o.s = q.s - (q.r + b);
			o.r = (q.r >> 1) + b;
		end else begin
			o.s = q.s;
			o.r = q.r >> 1;
		end
		return o;
	endfunction

	function automatic pp_t mul_pp(input word_t v, input word_t k);
		pp_t o;
		logic [63:0] t1;
		logic [63:0] t2;
		o.p0 = {32'd0, v[31:0]} * {32'd0, k[31:0]};
		t1 = {32'd0, v[31:0]} * {32'd0, k[63:32]};
		t2 = {32'd0, v[63:32]} * {32'd0, k[31:0]};
		o.p1 = t1[31:0];
		o.p2 = t2[31:0];
		return o;
	endfunction

	function automatic word_t pp_sum(input pp_t p);
		logic [31:0] h;
		h = p.p1 + p.p2;
		return p.p0 + {h, 32'd0};
	endfunction

endpackage

/* hdl/keyed_depth_arx_hash_mixer_core.sv */
// Keyed 64-bit hash mixer. One word is taken on every cycle that start is high (busy never
// rises); its hash leaves on hash_out with done high for one cycle. The pipeline holds the
// input register, depth and square sum, four stages of the 16-step square root, depth of
// the root, pre-mix, two stages per 64-bit product (32-bit partial products then their
// sum) for the rounds and for the final step. The receiver cannot stall: every result must
// be taken as it appears. The user must write key words through wr_en/wr_index/wr_data
// only while no word is in flight; the block itself does not enforce this.
`include "keyed_depth_arx_hash_mixer_core_assert.svh"

module keyed_depth_arx_hash_mixer_core
	import kdahm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [63:0]      value_in,
	output logic             done,
	output logic [63:0]      hash_out,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [63:0]      wr_data
);

	word_t key_q [NUM_KEYS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++)
				key_q[i] <= '0;
		end else if (wr_en && wr_index < IDX_W'(NUM_KEYS)) begin
			key_q[wr_index[1:0]] <= wr_data;
		end
	end

	assign busy = 1'b0;

	// input
	logic  v_s1;
	word_t x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		if (start)
			x_s1 <= value_in;
	end

	// depth and square sum, then square root
	logic   v_sq [SQ_STAGES+1];
	word_t  x_sq [SQ_STAGES+1];
	depth_t d_sq [SQ_STAGES+1];
	sq_t    q_sq [SQ_STAGES+1];

	logic [31:0] aa;
	logic [31:0] bb;
	assign aa = {16'd0, x_s1[15:0]} * {16'd0, x_s1[15:0]};
	assign bb = x_s1[47:16] * x_s1[47:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sq[0] <= 1'b0;
		else
			v_sq[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		x_sq[0]   <= x_s1;
		d_sq[0]   <= word_depth(x_s1);
		q_sq[0].s <= aa + bb;
		q_sq[0].r <= '0;
	end

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		sq_t q_c;
		always_comb begin
			q_c = q_sq[k];
			for (int j = 0; j < SQ_STEPS; j++)
				q_c = sq_step(q_c, 32'd1 << (30 - 2 * (k * SQ_STEPS + j)));
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_sq[k+1] <= 1'b0;
			else
				v_sq[k+1] <= v_sq[k];
		end

		always_ff @(posedge clk) begin
			x_sq[k+1] <= x_sq[k];
			d_sq[k+1] <= d_sq[k];
			q_sq[k+1] <= q_c;
		end
	end

	// depth of the root
	logic   v_sg;
	word_t  x_sg;
	depth_t d_sg;
	depth_t g_sg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sg <= 1'b0;
		else
			v_sg <= v_sq[SQ_STAGES];
	end

	always_ff @(posedge clk) begin
		x_sg <= x_sq[SQ_STAGES];
		d_sg <= d_sq[SQ_STAGES];
		g_sg <= word_depth({48'd0, q_sq[SQ_STAGES].r[15:0]});
	end

	// pre-mix
	logic   v_sp;
	word_t  p_sp;
	depth_t d_sp;
	word_t  t_sg;
	word_t  dk_sg;

	assign t_sg  = x_sg + {58'd0, g_sg};
	assign dk_sg = {58'd0, d_sg} * {32'd0, DEPTH_K};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sp <= 1'b0;
		else
			v_sp <= v_sg;
	end

	always_ff @(posedge clk) begin
		p_sp <= ((t_sg << 16) - t_sg + GOLDEN_K) ^ dk_sg;
		d_sp <= d_sg;
	end

	// rounds: partial products
	logic   v_e1;
	word_t  p_e1;
	depth_t d_e1;
	pp_t    pp_e1 [NUM_ROUNDS];
	word_t  sm_e1 [NUM_ROUNDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_e1 <= 1'b0;
		else
			v_e1 <= v_sp;
	end

	always_ff @(posedge clk) begin
		p_e1 <= p_sp;
		d_e1 <= d_sp;
		for (int i = 0; i < NUM_ROUNDS; i++) begin
			pp_e1[i] <= mul_pp(p_sp, round_mul(i));
			sm_e1[i] <= (p_sp >> (i + 1)) * {59'd0, round_prime(i)};
		end
	end

	// rounds: fold
	logic   v_e2;
	word_t  y_e2;
	depth_t d_e2;
	word_t  acc_e1;

	always_comb begin
		acc_e1 = '0;
		for (int i = 0; i < NUM_ROUNDS; i++) begin
			if ({26'd0, d_e1} >= 32'(i))
				acc_e1 = acc_e1 ^ rotl(pp_sum(pp_e1[i]) ^ sm_e1[i] ^ key_q[i % NUM_KEYS],
					round_rot(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_e2 <= 1'b0;
		else
			v_e2 <= v_e1;
	end

	always_ff @(posedge clk) begin
		y_e2 <= p_e1 ^ acc_e1;
		d_e2 <= d_e1;
	end

	// final step: xorshift and partial products
	logic       v_f1;
	pp_t        pp_f1;
	logic [5:0] rr_f1;
	logic [1:0] ki_f1;
	logic [1:0] sel_e2;
	logic [5:0] rp_e2;
	word_t      z_e2;

	always_comb begin
		sel_e2 = mod3(d_e2);
		rp_e2  = arx_rot(sel_e2);
		z_e2   = y_e2 ^ (y_e2 << rp_e2);
		z_e2   = z_e2 ^ (z_e2 >> rp_e2[5:1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_f1 <= 1'b0;
		else
			v_f1 <= v_e2;
	end

	always_ff @(posedge clk) begin
		pp_f1 <= mul_pp(z_e2, arx_mul(sel_e2));
		rr_f1 <= rp_e2 ^ d_e2;
		ki_f1 <= rp_e2[1:0] ^ d_e2[1:0];
	end

	// final step: sum, key, rotate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= v_f1;
	end

	always_ff @(posedge clk) begin
		hash_out <= rotl(pp_sum(pp_f1) ^ key_q[ki_f1], rr_f1);
	end

	`KDAHM_ASSERT(a_latency, start && !busy |-> ##LATENCY done, "accepted beat lost")
	`KDAHM_ASSERT(a_source, done |-> $past(start, LATENCY), "result without a beat")
	`KDAHM_ASSERT(a_round_src, v_e2 |-> $past(v_sp, 2), "round stage valid out of step")

endmodule
